[rtl/sorted_score_insertion_list_defines.svh]
// assertion macros shared by the sorted score list rtl
`ifndef SORTED_SCORE_INSERTION_LIST_DEFINES_SVH
`define SORTED_SCORE_INSERTION_LIST_DEFINES_SVH

`ifndef ASSERT_OFF

// property checked at every rising edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    `ASSERT_PROP(lbl, clk, rstn, !(cond), msg)

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)

`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

[rtl/ssil_pkg.sv]
// shared types and constants of the sorted score insertion list
`default_nettype none

package ssil_pkg;

    // default entries per list
    localparam int LIST_DEPTH_DEF = 256;

    // field widths
    localparam int POS_W   = 32;
    localparam int SCORE_W = 32;
    localparam int INDEX_W = 8;
    localparam int RANK_W  = 9;
    localparam int COUNT_W = 9;
    localparam int OP_W    = 2;

    // ranks addressable by a read
    localparam int IDX_SPAN = 2 ** INDEX_W;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    // one stored pair
    typedef struct packed {
        logic [POS_W-1:0]          position;
        logic signed [SCORE_W-1:0] score;
    } entry_t;

    // input item
    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic                      list_select;
        logic [POS_W-1:0]          position;
        logic signed [SCORE_W-1:0] score;
        logic [INDEX_W-1:0]        read_index;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [POS_W-1:0]          out_position;
        logic signed [SCORE_W-1:0] out_score;
        logic [RANK_W-1:0]         insert_rank;
        logic [COUNT_W-1:0]        entry_count;
        logic                      overflow;
        logic                      entry_valid;
    } out_item_t;

    // control and data broadcast to every cell
    typedef struct packed {
        logic               wr;
        logic               ins_op;
        logic               rd_op;
        logic               sel;
        entry_t             item;
        logic [INDEX_W-1:0] read_index;
    } bcast_t;

endpackage

`default_nettype wire

[rtl/ssil_cell.sv]
// one rank of both lists: compare, shift from the upper neighbor, tap for read or insert rank
`default_nettype none

module ssil_cell #(
    parameter int DEPTH = ssil_pkg::LIST_DEPTH_DEF,
    parameter int IDX   = 0
) (
    input  wire logic                                      aclk,
    input  wire ssil_pkg::bcast_t                          bcast,
    input  wire logic [$clog2(DEPTH+1)-1:0]                count,
    input  wire logic                                      prev_ge,
    input  wire ssil_pkg::entry_t [1:0]                    prev_ent,
    output logic                                           ge,
    output ssil_pkg::entry_t [1:0]                         ent_out,
    output logic [ssil_pkg::POS_W+ssil_pkg::SCORE_W+$clog2(DEPTH)-1:0] leaf
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int RW = $clog2(DEPTH);
    localparam logic                            IN_SPAN = (IDX < ssil_pkg::IDX_SPAN);
    localparam logic [ssil_pkg::INDEX_W-1:0]    IDX_LO  = ssil_pkg::INDEX_W'(IDX);
    localparam logic [CW-1:0]                   IDX_CW  = CW'(IDX);
    localparam logic [RW-1:0]                   IDX_RW  = RW'(IDX);

    ssil_pkg::entry_t [1:0] ent_reg;
    ssil_pkg::entry_t       cur;
    logic                   occupied;
    logic                   hit;

    // entry of the addressed list and its order against the new score
    always_comb begin
        cur      = ent_reg[bcast.sel];
        occupied = (IDX_CW < count);
        ge       = occupied && !(bcast.item.score > cur.score);
        hit      = (bcast.ins_op && prev_ge && !ge) ||
                   (bcast.rd_op && IN_SPAN && occupied && (bcast.read_index == IDX_LO));
        leaf     = hit ? {cur.position, cur.score, IDX_RW} : '0;
    end

    // keep, take the new pair, or take the neighbor's pair
    always_ff @(posedge aclk) begin
        if (bcast.wr && !ge) begin
            ent_reg[bcast.sel] <= prev_ge ? bcast.item : prev_ent[bcast.sel];
        end
    end

    assign ent_out = ent_reg;

endmodule

`default_nettype wire

[rtl/ssil_or_tree.sv]
// registered or-reduction tree gathering the one tapped cell
`default_nettype none

module ssil_or_tree #(
    parameter int N = 256,
    parameter int W = 72
) (
    input  wire logic         aclk,
    input  wire logic [W-1:0] leaf [N],
    output logic [W-1:0]      root
);

    localparam int LVLS = $clog2(N);
    localparam int NP   = 2 ** LVLS;

    // heap layout: node n has children 2n and 2n+1, leaves from NP up
    logic [W-1:0] node_reg [1:2*NP-1];

    always_ff @(posedge aclk) begin
        for (int n = 1; n < NP; n++) begin
            node_reg[n] <= node_reg[2*n] | node_reg[2*n+1];
        end
        for (int i = 0; i < NP; i++) begin
            node_reg[NP+i] <= (i < N) ? leaf[i] : '0;
        end
    end

    assign root = node_reg[1];

endmodule

`default_nettype wire

[rtl/sorted_score_insertion_list.sv]
// top level: two descending score lists held in a row of cells
//
//  channel | ports                     | payload
//  --------+---------------------------+--------------------------
//  input   | s_valid s_ready s_data    | ssil_pkg::in_item_t
//  result  | m_valid m_ready m_data    | ssil_pkg::out_item_t
//
// every cell updates in the cycle the item is accepted; the reply then walks
// the registered or-tree, log2(LIST_DEPTH) levels plus the leaf stage
// the result is loaded into the pending stage when the walk ends and moves on to the
// m_valid output register once that is empty or being taken; one item is in flight at a time
// a held result waits in a one-entry stage, the next item enters once it moves on
// aresetn (synchronous, active low) empties both lists and the control state
`default_nettype none

`include "sorted_score_insertion_list_defines.svh"

module sorted_score_insertion_list #(
    parameter int LIST_DEPTH = ssil_pkg::LIST_DEPTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire ssil_pkg::in_item_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output ssil_pkg::out_item_t       m_data
);

    localparam int LVLS = $clog2(LIST_DEPTH);
    localparam int RW   = LVLS;
    localparam int CW   = $clog2(LIST_DEPTH + 1);
    localparam int LW   = ssil_pkg::POS_W + ssil_pkg::SCORE_W + RW;
    localparam int CNTW = $clog2(LVLS + 1);
    localparam int CMPW = (CW > ssil_pkg::INDEX_W) ? CW : ssil_pkg::INDEX_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(LIST_DEPTH);

    // bookkeeping of the item in flight
    typedef struct packed {
        logic [ssil_pkg::OP_W-1:0]    op;
        logic                         dropped;
        logic                         overflow;
        logic                         rd_valid;
        logic [ssil_pkg::COUNT_W-1:0] count_after;
    } job_t;

    logic [CW-1:0]        counts_reg [2];
    logic [CW-1:0]        counts_next [2];
    logic                 active_reg, active_next;
    logic [CNTW-1:0]      cnt_reg, cnt_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic                 m_valid_reg, m_valid_next;
    job_t                 job_reg, job_next;
    ssil_pkg::out_item_t  pend_reg, pend_next;
    ssil_pkg::out_item_t  m_data_reg, m_data_next;

    logic                 acc;
    logic                 pend_load;
    logic                 pend_move;
    logic [CW-1:0]        cnt_sel;
    logic                 full;
    ssil_pkg::bcast_t     bcast;
    logic [LIST_DEPTH-1:0] ge_w;
    ssil_pkg::entry_t [1:0] ent_w [LIST_DEPTH];
    logic [LW-1:0]        leaf_w [LIST_DEPTH];
    logic [LW-1:0]        root;
    ssil_pkg::entry_t     root_ent;
    logic [RW-1:0]        root_rank;

    assign s_ready = !(active_reg || pend_valid_reg);
    assign acc     = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // broadcast to the cell row
    always_comb begin
        cnt_sel          = counts_reg[s_data.list_select];
        full             = (cnt_sel == FULL_CNT);
        bcast.wr         = acc && (s_data.operation == ssil_pkg::OP_INSERT);
        bcast.ins_op     = (s_data.operation == ssil_pkg::OP_INSERT);
        bcast.rd_op      = (s_data.operation == ssil_pkg::OP_READ);
        bcast.sel        = s_data.list_select;
        bcast.item       = '{position: s_data.position, score: s_data.score};
        bcast.read_index = s_data.read_index;
    end

    // row of cells, each but the first fed by its upper neighbor
    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
        ssil_cell #(
            .DEPTH (LIST_DEPTH),
            .IDX   (i)
        ) u_cell (
            .aclk     (aclk),
            .bcast    (bcast),
            .count    (cnt_sel),
            .prev_ge  ((i == 0) ? 1'b1 : ge_w[(i == 0) ? 0 : i - 1]),
            .prev_ent (ent_w[(i == 0) ? 0 : i - 1]),
            .ge       (ge_w[i]),
            .ent_out  (ent_w[i]),
            .leaf     (leaf_w[i])
        );
    end

    // gather the tapped cell
    ssil_or_tree #(
        .N (LIST_DEPTH),
        .W (LW)
    ) u_tree (
        .aclk (aclk),
        .leaf (leaf_w),
        .root (root)
    );

    assign root_ent  = root[LW-1:RW];
    assign root_rank = root[RW-1:0];

    // list counts and item bookkeeping
    always_comb begin
        counts_next          = counts_reg;
        job_next             = job_reg;
        job_next.op          = s_data.operation;
        job_next.dropped     = 1'b0;
        job_next.overflow    = 1'b0;
        job_next.rd_valid    = 1'b0;
        job_next.count_after = ssil_pkg::COUNT_W'(cnt_sel);
        case (s_data.operation)
            ssil_pkg::OP_INSERT: begin
                job_next.overflow = full;
                job_next.dropped  = full && ge_w[LIST_DEPTH-1];
                if (!full) begin
                    counts_next[s_data.list_select] = cnt_sel + 1'b1;
                    job_next.count_after = ssil_pkg::COUNT_W'(cnt_sel + 1'b1);
                end
            end
            ssil_pkg::OP_READ: begin
                job_next.rd_valid = (CMPW'(s_data.read_index) < CMPW'(cnt_sel));
            end
            ssil_pkg::OP_CLEAR: begin
                counts_next[s_data.list_select] = '0;
                job_next.count_after = '0;
            end
            default: begin
            end
        endcase
        if (!acc) begin
            counts_next = counts_reg;
            job_next    = job_reg;
        end
    end

    // result formatting when the tree walk ends
    always_comb begin
        pend_next             = '0;
        pend_next.entry_count = job_reg.count_after;
        case (job_reg.op)
            ssil_pkg::OP_INSERT: begin
                pend_next.overflow    = job_reg.overflow;
                pend_next.insert_rank = job_reg.dropped ?
                    ssil_pkg::RANK_W'(LIST_DEPTH) : ssil_pkg::RANK_W'(root_rank);
            end
            ssil_pkg::OP_READ: begin
                pend_next.entry_valid = job_reg.rd_valid;
                if (job_reg.rd_valid) begin
                    pend_next.out_position = root_ent.position;
                    pend_next.out_score    = root_ent.score;
                end
            end
            default: begin
            end
        endcase
    end

    // sequencing of the item in flight and the output stage
    always_comb begin
        pend_load       = active_reg && (cnt_reg == '0);
        pend_move       = pend_valid_reg && (!m_valid_reg || m_ready);
        active_next     = active_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        if (acc) begin
            active_next = 1'b1;
            cnt_next    = CNTW'(LVLS);
        end else if (pend_load) begin
            active_next     = 1'b0;
            pend_valid_next = 1'b1;
        end else if (active_reg) begin
            cnt_next = cnt_reg - 1'b1;
        end
        if (pend_move) begin
            pend_valid_next = 1'b0;
            m_valid_next    = 1'b1;
            m_data_next     = pend_reg;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counts_reg[0]  <= '0;
            counts_reg[1]  <= '0;
            active_reg     <= 1'b0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            counts_reg     <= counts_next;
            active_reg     <= active_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        job_reg    <= job_next;
        m_data_reg <= m_data_next;
        if (pend_load) begin
            pend_reg <= pend_next;
        end
    end

    // checks
    `ASSERT_PROP(a_count_bound, aclk, aresetn, (counts_reg[0] <= FULL_CNT) && (counts_reg[1] <= FULL_CNT), "list count above depth")
    `ASSERT_PROP(a_one_in_flight, aclk, aresetn, acc |=> !s_ready, "second item taken while one is in flight")
    `ASSERT_NEVER(a_active_pend, aclk, aresetn, active_reg && pend_valid_reg, "tree walk and held result overlap")
    `ASSERT_PROP(a_insert_grows, aclk, aresetn, (acc && (s_data.operation == ssil_pkg::OP_INSERT) && !s_data.list_select && (counts_reg[0] != FULL_CNT)) |=> (counts_reg[0] == $past(counts_reg[0]) + 1'b1), "insert into list 0 did not grow it")

endmodule

`default_nettype wire

[bench/sorted_score_insertion_list_tb.sv]
`timescale 1ns / 100ps
// self-checking bench for the sorted score insertion list: directed rows, then random traffic
module sorted_score_insertion_list_tb;

    localparam int DEPTH = ssil_pkg::LIST_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 2000;
    localparam int ROUNDS = 4;
    localparam int DRAIN_CYCLES = 24;
    localparam logic [ssil_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    // one directed row; want is used only where typed is set
    typedef struct {
        ssil_pkg::in_item_t  stim;
        bit                  typed;
        ssil_pkg::out_item_t want;
    } dir_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    ssil_pkg::in_item_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    ssil_pkg::out_item_t m_data;

    // shadow copy of both lists
    logic [ssil_pkg::POS_W-1:0]          list_pos [2][DEPTH];
    logic signed [ssil_pkg::SCORE_W-1:0] list_score [2][DEPTH];
    int unsigned                         list_len [2] = '{0, 0};

    ssil_pkg::out_item_t pending_replies [$];
    dir_row_t            directed_rows [$];
    int unsigned         mismatch_count = 0;

    sorted_score_insertion_list #(
        .LIST_DEPTH(DEPTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // apply one item to the shadow lists and return the reply it should produce
    function automatic ssil_pkg::out_item_t apply_list_op(ssil_pkg::in_item_t it);
        ssil_pkg::out_item_t res;
        int unsigned         sel;
        int unsigned         cnt;
        int unsigned         r;
        int unsigned         top;
        res = '0;
        sel = it.list_select;
        cnt = list_len[sel];
        case (it.operation)
            ssil_pkg::OP_INSERT: begin
                // land after every entry with greater or equal score
                r = 0;
                while (r < cnt && !($signed(it.score) > list_score[sel][r]))
                    r++;
                if (r >= DEPTH) begin
                    // full list and new pair ranks after every entry: drop it
                    res.insert_rank = ssil_pkg::RANK_W'(DEPTH);
                    res.overflow = 1'b1;
                end else begin
                    top = cnt;
                    if (cnt == DEPTH) begin
                        top = DEPTH - 1;
                        res.overflow = 1'b1;
                    end else begin
                        cnt++;
                    end
                    for (int unsigned j = top; j > r; j--) begin
                        list_pos[sel][j] = list_pos[sel][j-1];
                        list_score[sel][j] = list_score[sel][j-1];
                    end
                    list_pos[sel][r] = it.position;
                    list_score[sel][r] = it.score;
                    res.insert_rank = ssil_pkg::RANK_W'(r);
                end
                list_len[sel] = cnt;
            end
            ssil_pkg::OP_READ: begin
                if (it.read_index < cnt) begin
                    res.out_position = list_pos[sel][it.read_index];
                    res.out_score = list_score[sel][it.read_index];
                    res.entry_valid = 1'b1;
                end
            end
            ssil_pkg::OP_CLEAR: begin
                cnt = 0;
                list_len[sel] = 0;
            end
            default: begin
            end
        endcase
        res.entry_count = ssil_pkg::COUNT_W'(cnt);
        return res;
    endfunction

    // reply with only rank and count set
    function automatic ssil_pkg::out_item_t plain_result(int unsigned rank, int unsigned cnt);
        ssil_pkg::out_item_t res;
        res = '0;
        res.insert_rank = ssil_pkg::RANK_W'(rank);
        res.entry_count = ssil_pkg::COUNT_W'(cnt);
        return res;
    endfunction

    // idle length: mostly none or short, a few long
    function automatic int unsigned pick_gap(bit quiet);
        int unsigned roll;
        if (quiet)
            return 0;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(3, 1);
        if (roll < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // random item, mostly inserts into the favored list so lists fill and overflow
    function automatic ssil_pkg::in_item_t random_item(bit favored);
        ssil_pkg::in_item_t it;
        int unsigned        roll;
        int unsigned        cnt;
        it.list_select = ($urandom_range(99) < 85) ? favored : ~favored;
        cnt = list_len[it.list_select];
        roll = $urandom_range(999);
        if (roll < 4)
            it.operation = ssil_pkg::OP_CLEAR;
        else if (roll < 24)
            it.operation = OP_UNUSED;
        else if (roll < 274)
            it.operation = ssil_pkg::OP_READ;
        else
            it.operation = ssil_pkg::OP_INSERT;
        it.position = $urandom();
        // extremes and scores already held give ties and smallest-score drops
        case ($urandom_range(15))
            0: it.score = 32'sh7FFF_FFFF;
            1: it.score = 32'sh8000_0000;
            2: it.score = 32'sh0000_0000;
            3: it.score = -32'sd1;
            4: it.score = 32'sh0001_0000;
            5, 6: begin
                if (cnt > 0)
                    it.score = list_score[it.list_select][$urandom_range(cnt - 1)];
                else
                    it.score = $urandom();
            end
            default: it.score = $urandom();
        endcase
        if (cnt > 0 && $urandom_range(9) < 7)
            it.read_index = ssil_pkg::INDEX_W'($urandom_range(cnt - 1));
        else
            it.read_index = ssil_pkg::INDEX_W'($urandom_range(ssil_pkg::IDX_SPAN - 1));
        return it;
    endfunction

    task automatic add_row(logic [ssil_pkg::OP_W-1:0] op, bit sel,
                           logic [ssil_pkg::POS_W-1:0] pos,
                           logic [ssil_pkg::SCORE_W-1:0] sco,
                           logic [ssil_pkg::INDEX_W-1:0] idx,
                           bit typed, ssil_pkg::out_item_t want);
        dir_row_t row;
        row.stim.operation = op;
        row.stim.list_select = sel;
        row.stim.position = pos;
        row.stim.score = sco;
        row.stim.read_index = idx;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    // present one item after a random gap (none when quiet), then record its reply once accepted
    task automatic send_item(ssil_pkg::in_item_t it, bit typed, ssil_pkg::out_item_t want,
                             bit quiet);
        int unsigned         gap;
        ssil_pkg::out_item_t predicted;
        gap = pick_gap(quiet);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_list_op(it);
        pending_replies.push_back(typed ? want : predicted);
    endtask

    task automatic compare_fields(ssil_pkg::out_item_t want, ssil_pkg::out_item_t got);
        if (got.out_position !== want.out_position) begin
            $display("%0t: out_position expected %h got %h", $time,
                     want.out_position, got.out_position);
            mismatch_count++;
        end
        if (got.out_score !== want.out_score) begin
            $display("%0t: out_score expected %h got %h", $time,
                     want.out_score, got.out_score);
            mismatch_count++;
        end
        if (got.insert_rank !== want.insert_rank) begin
            $display("%0t: insert_rank expected %0d got %0d", $time,
                     want.insert_rank, got.insert_rank);
            mismatch_count++;
        end
        if (got.entry_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d got %0d", $time,
                     want.entry_count, got.entry_count);
            mismatch_count++;
        end
        if (got.overflow !== want.overflow) begin
            $display("%0t: overflow expected %b got %b", $time,
                     want.overflow, got.overflow);
            mismatch_count++;
        end
        if (got.entry_valid !== want.entry_valid) begin
            $display("%0t: entry_valid expected %b got %b", $time,
                     want.entry_valid, got.entry_valid);
            mismatch_count++;
        end
    endtask

    // result side: check every accepted item against the oldest pending reply
    always @(posedge aclk) begin
        ssil_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: result expected none got %h", $time, m_data);
                mismatch_count++;
            end else begin
                want = pending_replies.pop_front();
                compare_fields(want, m_data);
            end
        end
    end

    // result back-pressure: short ready runs with stalls, now and then a long open stretch
    initial begin
        int unsigned run;
        int unsigned stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if ($urandom_range(15) == 0)
                run = $urandom_range(300, 100);
            else
                run = $urandom_range(8, 1);
            m_ready <= 1'b1;
            repeat (run) @(posedge aclk);
            stall = pick_gap(1'b0);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // stimulus: directed rows, then random rounds, then drain
    initial begin
        bit favored;
        bit quiet;

        // empty lists, extremes, ties, reads in and beyond range, clear, unused code
        add_row(ssil_pkg::OP_READ, 1'b0, '0, '0, '0, 1'b1, plain_result(0, 0));
        add_row(ssil_pkg::OP_CLEAR, 1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 8'hFF,
                1'b1, plain_result(0, 0));
        add_row(OP_UNUSED, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, plain_result(0, 0));
        add_row(ssil_pkg::OP_INSERT, 1'b0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 8'h00,
                1'b1, plain_result(0, 1));
        add_row(ssil_pkg::OP_INSERT, 1'b0, 32'h0000_0000, 32'h8000_0000, 8'hFF,
                1'b1, plain_result(1, 2));
        add_row(ssil_pkg::OP_INSERT, 1'b0, 32'h0000_0001, 32'h7FFF_FFFF, 8'h00,
                1'b1, plain_result(1, 3));
        add_row(ssil_pkg::OP_INSERT, 1'b0, 32'h0000_0002, 32'h0000_0000, 8'h00, 1'b0, '0);
        add_row(ssil_pkg::OP_INSERT, 1'b0, 32'h0000_0003, 32'hFFFF_FFFF, 8'h00, 1'b0, '0);
        add_row(ssil_pkg::OP_INSERT, 1'b0, 32'h0000_0004, 32'h0001_0000, 8'h00, 1'b0, '0);
        add_row(ssil_pkg::OP_INSERT, 1'b1, 32'h1234_5678, 32'h0001_0000, 8'h00,
                1'b1, plain_result(0, 1));
        add_row(ssil_pkg::OP_READ, 1'b0, '0, '0, 8'd0, 1'b0, '0);
        add_row(ssil_pkg::OP_READ, 1'b0, '0, '0, 8'd1, 1'b0, '0);
        add_row(ssil_pkg::OP_READ, 1'b0, '0, '0, 8'd2, 1'b0, '0);
        add_row(ssil_pkg::OP_READ, 1'b0, '0, '0, 8'd3, 1'b0, '0);
        add_row(ssil_pkg::OP_READ, 1'b0, '0, '0, 8'd4, 1'b0, '0);
        add_row(ssil_pkg::OP_READ, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b0, '0);
        add_row(ssil_pkg::OP_READ, 1'b1, '0, '0, 8'd0, 1'b0, '0);
        add_row(OP_UNUSED, 1'b1, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 8'hA5, 1'b0, '0);
        add_row(ssil_pkg::OP_INSERT, 1'b1, 32'hA5A5_A5A5, 32'h8000_0000, 8'h5A, 1'b0, '0);
        add_row(ssil_pkg::OP_READ, 1'b1, '0, '0, 8'd1, 1'b0, '0);
        add_row(ssil_pkg::OP_CLEAR, 1'b0, '0, '0, '0, 1'b1, plain_result(0, 0));
        add_row(ssil_pkg::OP_READ, 1'b0, '0, '0, 8'd0, 1'b1, plain_result(0, 0));
        add_row(ssil_pkg::OP_INSERT, 1'b0, 32'h5A5A_5A5A, 32'h8000_0000, 8'h00,
                1'b1, plain_result(0, 1));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want, 1'b0);

        // one round runs with no gaps on the input side
        for (int round = 0; round < ROUNDS; round++) begin
            favored = $urandom_range(1);
            quiet = (round == 2);
            for (int n = 0; n < RANDOM_ITEMS / ROUNDS; n++)
                send_item(random_item(favored), 1'b0, '0, quiet);
        end
        s_valid <= 1'b0;

        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("sorted_score_insertion_list_tb OK");
        else
            $display("sorted_score_insertion_list_tb NOT OK");
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial begin
        #10_000_000;
        $display("sorted_score_insertion_list_tb NOT OK");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/ssil_pkg.sv
rtl/ssil_cell.sv
rtl/ssil_or_tree.sv
rtl/sorted_score_insertion_list.sv
bench/sorted_score_insertion_list_tb.sv
